/* hdl/kvp_pkg.sv */
// ----------------------------------------------------------------------------
// kvp_pkg: shared types and constants for the key-value request parser
// Item layouts, protocol byte codes, opcode and status codes, length widths.
// ----------------------------------------------------------------------------
package kvp_pkg;

	// largest argument length a request may announce
	localparam int MAX_LEN    = 65535;
	localparam int LEN_W      = $clog2(MAX_LEN + 1);
	localparam int OUT_LEN_W  = 16;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// protocol bytes
	localparam logic [7:0] CH_GET    = 8'h67; // g
	localparam logic [7:0] CH_SET    = 8'h73; // s
	localparam logic [7:0] CH_REMOVE = 8'h72; // r
	localparam logic [7:0] CH_CAS    = 8'h63; // c
	localparam logic [7:0] CH_INFO   = 8'h69; // i
	localparam logic [7:0] CH_RESET  = 8'h52; // R
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// opcodes
	localparam logic [2:0] OP_GET     = 3'd0;
	localparam logic [2:0] OP_SET     = 3'd1;
	localparam logic [2:0] OP_DELETE  = 3'd2;
	localparam logic [2:0] OP_CAS     = 3'd3;
	localparam logic [2:0] OP_INFO    = 3'd4;
	localparam logic [2:0] OP_CLEAR   = 3'd5;
	localparam logic [2:0] OP_UNKNOWN = 3'd6;

	// verdict status
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FAIL      = 2'd1;
	localparam logic [1:0] ST_DEBUG_OFF = 2'd2;

	// result item kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// number of results one byte produces
	localparam logic [1:0] PUSH_NONE = 2'd0;
	localparam logic [1:0] PUSH_ONE  = 2'd1;
	localparam logic [1:0] PUSH_TWO  = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} kvp_in_t;

	typedef struct packed {
		logic                 kind;
		logic [1:0]           arg_index;
		logic [7:0]           payload;
		logic [2:0]           op_code;
		logic [1:0]           status;
		logic [OUT_LEN_W-1:0] key_length;
		logic [OUT_LEN_W-1:0] first_value_length;
		logic [OUT_LEN_W-1:0] second_value_length;
	} kvp_out_t;

	// results of one parsed byte, in order, handed to the result queue
	typedef struct packed {
		logic [1:0] cnt;
		kvp_out_t   item0;
		kvp_out_t   item1;
	} kvp_push_t;

	// verdict lengths carry the low bits of the parsed length
	function automatic logic [OUT_LEN_W-1:0] out_len(input logic [LEN_W-1:0] len);
		logic [LEN_W+OUT_LEN_W-1:0] ext;
		ext = {{OUT_LEN_W{1'b0}}, len};
		return ext[OUT_LEN_W-1:0];
	endfunction

endpackage

/* hdl/kv_request_frame_parser.sv */
// ----------------------------------------------------------------------------
// kv_request_frame_parser: byte-serial key-value request parser
// Input register, one-pass parse logic and a four-entry result queue.
// ----------------------------------------------------------------------------
// Takes one request byte per cycle while in_ready is high. Each byte is captured
// in an input register and parsed from there; its results (an argument payload
// item, a verdict item, both, or nothing) go into a four-entry result queue,
// which registers them before they are offered. Input is accepted back to back
// as long as the queue has room for two more items; a byte that yields both a
// payload item and a verdict uses two queue slots, and only a consumer that
// holds out_ready low makes the input stall. The user must write debug_enabled
// through cfg_we/cfg_wdata only while the block is idle; it is not enforced.
module kv_request_frame_parser
	import kvp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  kvp_in_t  in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output kvp_out_t out_item,
	input  logic     cfg_we,
	input  logic     cfg_wdata
);

	logic             debug_q;
	logic             v_s1;
	kvp_in_t          in_s1;
	logic             advance;
	logic [CNT_W-1:0] fifo_count;
	kvp_push_t        push;

	// parse the held byte when the queue can take two results
	assign advance  = v_s1 && (fifo_count <= CNT_W'(FIFO_DEPTH - 2));
	assign in_ready = !v_s1 || advance;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debug_q <= 1'b0;
		end else if (cfg_we) begin
			debug_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) in_s1 <= in_item;
	end

	kvp_parse_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.in_item       (in_s1),
		.debug_enabled (debug_q),
		.push          (push)
	);

	kvp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.count     (fifo_count)
	);

	// queue never overfills
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= CNT_W'(FIFO_DEPTH))
		else $error("result queue over capacity");

	// results only come from a parsed byte
	a_push_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != PUSH_NONE) |-> advance)
		else $error("result pushed without a parsed byte");

	// two results from one byte: payload first, verdict second
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == PUSH_TWO) |->
			(push.item0.kind == KIND_PAYLOAD && push.item1.kind == KIND_VERDICT))
		else $error("result order wrong for a two-result byte");

	// a held byte that cannot be parsed stays in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !advance) |=> (v_s1 && $stable(in_s1)))
		else $error("input register lost a byte");

endmodule

/* hdl/kvp_parse_core.sv */
// ----------------------------------------------------------------------------
// kvp_parse_core: per-byte request parser
// Holds the request state and turns one registered byte into up to two results.
// ----------------------------------------------------------------------------
module kvp_parse_core
	import kvp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  kvp_in_t   in_item,
	input  logic      debug_enabled,
	output kvp_push_t push
);

	typedef enum logic [7:0] {
		PH_OP        = 8'b0000_0001,
		PH_CR_OP     = 8'b0000_0010,
		PH_LEN_FIRST = 8'b0000_0100,
		PH_LEN_MORE  = 8'b0000_1000,
		PH_DATA      = 8'b0001_0000,
		PH_CR_ARG    = 8'b0010_0000,
		PH_CR_FINAL  = 8'b0100_0000,
		PH_DRAIN     = 8'b1000_0000
	} kvp_phase_t;

	localparam logic [LEN_W+3:0] MAX_LEN_V = (LEN_W + 4)'(MAX_LEN);

	kvp_phase_t       phase_q, phase_n;
	logic [2:0]       op_q, op_n;
	logic [1:0]       arg_q, arg_n;
	logic [LEN_W-1:0] bc_q, bc_n;
	logic [LEN_W-1:0] len_q [3];
	logic [LEN_W-1:0] len_n [3];

	logic [1:0]       arg;
	logic             is_digit;
	logic [3:0]       dig;
	logic [LEN_W-1:0] len_cur;
	logic [LEN_W+3:0] nv;
	logic [LEN_W:0]   bc_inc;
	logic [1:0]       fin_arg;
	logic             done;
	logic             pay;
	logic [1:0]       st;
	kvp_out_t         pay_item;
	kvp_out_t         ver_item;

	function automatic logic [2:0] decode_op(input logic [7:0] b);
		logic [2:0] op;
		unique case (b)
			CH_GET:    op = OP_GET;
			CH_SET:    op = OP_SET;
			CH_REMOVE: op = OP_DELETE;
			CH_CAS:    op = OP_CAS;
			CH_INFO:   op = OP_INFO;
			CH_RESET:  op = OP_CLEAR;
			default:   op = OP_UNKNOWN;
		endcase
		return op;
	endfunction

	// operand decode shared by the phases
	always_comb begin
		arg      = (arg_q == 2'd3) ? 2'd2 : arg_q;
		is_digit = (in_item.data >= CH_ZERO) && (in_item.data <= CH_NINE);
		dig      = in_item.data[3:0];
		len_cur  = len_q[arg];
		nv       = ({4'b0, len_cur} << 3) + ({4'b0, len_cur} << 1) + {{LEN_W{1'b0}}, dig};
		bc_inc   = {1'b0, bc_q} + 1'b1;
		fin_arg  = (op_q == OP_SET) ? 2'd1 : ((op_q == OP_CAS) ? 2'd2 : 2'd0);
	end

	// next state and results
	always_comb begin
		phase_n = phase_q;
		op_n    = op_q;
		arg_n   = arg_q;
		bc_n    = bc_q;
		for (int i = 0; i < 3; i++) begin
			len_n[i] = len_q[i];
		end
		done = 1'b0;
		pay  = 1'b0;
		st   = ST_FAIL;

		unique case (phase_q)
			PH_OP: begin
				op_n = decode_op(in_item.data);
				if (op_n == OP_UNKNOWN) done = 1'b1;
				else phase_n = PH_CR_OP;
			end
			PH_CR_OP: begin
				if (in_item.data != CH_CR) begin
					done = 1'b1;
				end else if (op_q == OP_INFO || op_q == OP_CLEAR) begin
					phase_n = PH_CR_FINAL;
				end else begin
					arg_n   = 2'd0;
					phase_n = PH_LEN_FIRST;
				end
			end
			PH_LEN_FIRST: begin
				if (!is_digit || {{LEN_W{1'b0}}, dig} > MAX_LEN_V) begin
					done = 1'b1;
				end else begin
					len_n[arg] = LEN_W'(dig);
					phase_n    = PH_LEN_MORE;
				end
			end
			PH_LEN_MORE: begin
				if (is_digit) begin
					if (nv > MAX_LEN_V) done = 1'b1;
					else len_n[arg] = nv[LEN_W-1:0];
				end else if (len_cur == '0) begin
					// zero length: this byte is the argument's carriage return
					if (in_item.data != CH_CR) begin
						done = 1'b1;
					end else if (arg >= fin_arg) begin
						phase_n = PH_CR_FINAL;
					end else begin
						arg_n   = arg + 2'd1;
						phase_n = PH_LEN_FIRST;
					end
				end else begin
					// first non-digit is already the first data byte
					pay     = 1'b1;
					bc_n    = LEN_W'(1);
					phase_n = (len_cur == LEN_W'(1)) ? PH_CR_ARG : PH_DATA;
				end
			end
			PH_DATA: begin
				pay  = 1'b1;
				bc_n = bc_inc[LEN_W-1:0];
				if (bc_inc >= {1'b0, len_cur}) phase_n = PH_CR_ARG;
			end
			PH_CR_ARG: begin
				if (in_item.data != CH_CR) begin
					done = 1'b1;
				end else if (arg >= fin_arg) begin
					phase_n = PH_CR_FINAL;
				end else begin
					arg_n   = arg + 2'd1;
					phase_n = PH_LEN_FIRST;
				end
			end
			PH_CR_FINAL: begin
				done = 1'b1;
				if (in_item.data != CH_CR) st = ST_FAIL;
				else if (op_q == OP_CLEAR && !debug_enabled) st = ST_DEBUG_OFF;
				else st = ST_OK;
			end
			PH_DRAIN: begin
			end
			default: begin
			end
		endcase

		// truncated request
		if (!done && in_item.last && phase_q != PH_DRAIN) begin
			done = 1'b1;
			st   = ST_FAIL;
		end

		// verdict fields use the state as updated by this byte
		pay_item           = '0;
		pay_item.kind      = KIND_PAYLOAD;
		pay_item.arg_index = arg;
		pay_item.payload   = in_item.data;

		ver_item                     = '0;
		ver_item.kind                = KIND_VERDICT;
		ver_item.op_code             = op_n;
		ver_item.status              = st;
		ver_item.key_length          = out_len(len_n[0]);
		ver_item.first_value_length  = out_len(len_n[1]);
		ver_item.second_value_length = out_len(len_n[2]);

		push       = '0;
		push.item0 = pay ? pay_item : ver_item;
		push.item1 = ver_item;
		if (step) begin
			if (pay && done) push.cnt = PUSH_TWO;
			else if (pay || done) push.cnt = PUSH_ONE;
			else push.cnt = PUSH_NONE;
		end

		// end of request clears everything; after an early verdict the rest is drained
		if (in_item.last) begin
			phase_n = PH_OP;
			op_n    = '0;
			arg_n   = '0;
			bc_n    = '0;
			for (int i = 0; i < 3; i++) begin
				len_n[i] = '0;
			end
		end else if (done) begin
			phase_n = PH_DRAIN;
		end
	end

	// request state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OP;
			op_q    <= '0;
			arg_q   <= '0;
			bc_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				len_q[i] <= '0;
			end
		end else if (step) begin
			phase_q <= phase_n;
			op_q    <= op_n;
			arg_q   <= arg_n;
			bc_q    <= bc_n;
			for (int i = 0; i < 3; i++) begin
				len_q[i] <= len_n[i];
			end
		end
	end

endmodule

/* hdl/kvp_out_fifo.sv */
// ----------------------------------------------------------------------------
// kvp_out_fifo: result queue
// Small queue that takes up to two result items per cycle and hands out one.
// ----------------------------------------------------------------------------
module kvp_out_fifo
	import kvp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  kvp_push_t        push,
	output logic             out_valid,
	input  logic             out_ready,
	output kvp_out_t         out_item,
	output logic [CNT_W-1:0] count
);

	kvp_out_t         mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign count     = count_q;

	// storage, first item at the write pointer, second one after it
	always_ff @(posedge clk) begin
		if (push.cnt != PUSH_NONE) mem_q[wr_ptr_q] <= push.item0;
		if (push.cnt == PUSH_TWO) mem_q[wr_ptr_q + PTR_W'(1)] <= push.item1;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.cnt);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

endmodule
